FILE: hw/rtl/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
// no dependencies; imported by every module of the block
package sem_pkg;

    // pixel and configuration widths
    localparam int PIX_W        = 8;
    localparam int CFG_W        = 11;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int MIN_SIZE     = 3;
    localparam int SIZE_RESET   = 1024;

    // gradient and magnitude widths
    localparam int GRAD_W = 11;
    localparam int SQ_W   = 2 * GRAD_W - 2;
    localparam int SUM_W  = SQ_W + 1;
    localparam int RAD_W  = 16;
    localparam int ROOT_W = RAD_W + 1;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam logic [PIX_W-1:0] EDGE_MAX = 8'hFF;

    // result queue
    localparam int QUEUE_DEPTH = 16;
    localparam int OUTS_W      = $clog2(QUEUE_DEPTH + 1);

    // register interface
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // side information that travels with each pixel
    typedef struct packed {
        logic produce;
        logic last;
    } tag_t;

    // one result item
    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             clipped;
        logic             last_of_frame;
    } res_t;

endpackage

FILE: hw/rtl/sem_line_store.sv
// two line stores held as one 16-bit wide synchronous memory, read-modify-write
// with forwarding for back-to-back requests to the same column; uses sem_pkg
module sem_line_store #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] req_addr,
    input  logic [sem_pkg::PIX_W-1:0]    req_pixel,
    input  sem_pkg::tag_t                req_tag,
    output logic                         rsp_valid,
    output logic [sem_pkg::PIX_W-1:0]    rsp_pixel,
    output logic [sem_pkg::PIX_W-1:0]    rsp_upper,
    output logic [sem_pkg::PIX_W-1:0]    rsp_lower,
    output sem_pkg::tag_t                rsp_tag
);
    import sem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    // entry holds {upper row, lower row}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

    logic               s1_valid_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [PIX_W-1:0]   s1_pixel_reg;
    tag_t               s1_tag_reg;
    logic [2*PIX_W-1:0] rd_data_reg;
    logic               fwd_hit_reg;
    logic               fwd_hit_next;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic [2*PIX_W-1:0] entry;
    logic [2*PIX_W-1:0] wr_data;

    // forwarded data wins over a read that raced the write
    assign entry   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data = {entry[PIX_W-1:0], s1_pixel_reg};
    assign fwd_hit_next = s1_valid_reg && req_valid && (req_addr == s1_addr_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req_valid;
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

    // memory port and request payload
    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            rd_data_reg  <= line_mem[req_addr];
            s1_addr_reg  <= req_addr;
            s1_pixel_reg <= req_pixel;
            s1_tag_reg   <= req_tag;
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_addr_reg] <= wr_data;
        end
        fwd_data_reg <= wr_data;
    end

    assign rsp_valid = s1_valid_reg;
    assign rsp_pixel = s1_pixel_reg;
    assign rsp_upper = entry[2*PIX_W-1:PIX_W];
    assign rsp_lower = entry[PIX_W-1:0];
    assign rsp_tag   = s1_tag_reg;

endmodule

FILE: hw/rtl/sem_gradient.sv
// 3x3 window of the two newest columns plus the incoming one, and the
// horizontal and vertical sobel sums; uses sem_pkg
module sem_gradient (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               col_valid,
    input  sem_pkg::tag_t                      col_tag,
    input  logic [sem_pkg::PIX_W-1:0]          col_pixel,
    input  logic [sem_pkg::PIX_W-1:0]          col_upper,
    input  logic [sem_pkg::PIX_W-1:0]          col_lower,
    output logic                               grad_valid,
    output logic signed [sem_pkg::GRAD_W-1:0]  gx,
    output logic signed [sem_pkg::GRAD_W-1:0]  gy,
    output logic                               grad_last
);
    import sem_pkg::*;

    function automatic logic signed [GRAD_W-1:0] ext(input logic [PIX_W-1:0] v);
        return $signed(GRAD_W'(v));
    endfunction

    // row 0 is the oldest line, row 2 the incoming pixel
    logic [2:0][PIX_W-1:0] mid_col_reg;
    logic [2:0][PIX_W-1:0] new_col_reg;
    logic [2:0][PIX_W-1:0] in_col;

    logic                     grad_valid_reg;
    logic                     grad_valid_next;
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic signed [GRAD_W-1:0] gx_next;
    logic signed [GRAD_W-1:0] gy_next;
    logic                     last_reg;

    assign in_col = {col_pixel, col_lower, col_upper};

    // kernels on the shifted window: left = mid, center = new, right = incoming
    always_comb
    begin
        gx_next = (ext(in_col[0]) - ext(mid_col_reg[0]))
                + ((ext(in_col[1]) - ext(mid_col_reg[1])) <<< 1)
                + (ext(in_col[2]) - ext(mid_col_reg[2]));
        gy_next = (ext(mid_col_reg[0]) - ext(mid_col_reg[2]))
                + ((ext(new_col_reg[0]) - ext(new_col_reg[2])) <<< 1)
                + (ext(in_col[0]) - ext(in_col[2]));
        grad_valid_next = col_valid && col_tag.produce;
    end

    // window shift and valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_col_reg    <= '0;
            new_col_reg    <= '0;
            grad_valid_reg <= 1'b0;
        end
        else
        begin
            grad_valid_reg <= grad_valid_next;
            if (col_valid)
            begin
                mid_col_reg <= new_col_reg;
                new_col_reg <= in_col;
            end
        end
    end

    // gradient payload
    always_ff @(posedge clk)
    begin
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        last_reg <= col_tag.last;
    end

    assign grad_valid = grad_valid_reg;
    assign gx         = gx_reg;
    assign gy         = gy_reg;
    assign grad_last  = last_reg;

endmodule

FILE: hw/rtl/sem_magnitude.sv
// squares, sum with saturation check, and an eight stage pipelined
// restoring square root, one result bit per stage; uses sem_pkg
module sem_magnitude (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              grad_valid,
    input  logic signed [sem_pkg::GRAD_W-1:0] gx,
    input  logic signed [sem_pkg::GRAD_W-1:0] gy,
    input  logic                              grad_last,
    output logic                              mag_valid,
    output sem_pkg::res_t                     mag_res
);
    import sem_pkg::*;

    logic signed [2*GRAD_W-1:0] prod_x;
    logic signed [2*GRAD_W-1:0] prod_y;
    logic [SUM_W-1:0]           sum;

    logic            sq_valid_reg;
    logic [SQ_W-1:0] sqx_reg;
    logic [SQ_W-1:0] sqy_reg;
    logic            sq_last_reg;

    logic [SQRT_STEPS:0]  st_valid_reg;
    logic [SQRT_STEPS:0]  st_valid_next;
    logic [ROOT_W-1:0]    rem_reg  [SQRT_STEPS+1];
    logic [ROOT_W-1:0]    rem_next [SQRT_STEPS+1];
    logic [ROOT_W-1:0]    root_reg [SQRT_STEPS+1];
    logic [ROOT_W-1:0]    root_next[SQRT_STEPS+1];
    logic [SQRT_STEPS:0]  clip_reg;
    logic [SQRT_STEPS:0]  clip_next;
    logic [SQRT_STEPS:0]  last_reg;
    logic [SQRT_STEPS:0]  last_next;

    // squares of the gradients
    assign prod_x = gx * gx;
    assign prod_y = gy * gy;
    assign sum    = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);

    // root stages: stage k tests bit 2^(14-2k) of the radicand
    always_comb
    begin
        logic [ROOT_W-1:0] trial;
        logic [ROOT_W-1:0] bitv;
        st_valid_next = {st_valid_reg[SQRT_STEPS-1:0], sq_valid_reg};
        rem_next[0]   = ROOT_W'(sum[RAD_W-1:0]);
        root_next[0]  = '0;
        clip_next[0]  = |sum[SUM_W-1:RAD_W];
        last_next[0]  = sq_last_reg;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            bitv  = ROOT_W'(1) << (RAD_W - 2 - 2 * k);
            trial = root_reg[k] + bitv;
            if (rem_reg[k] >= trial)
            begin
                rem_next[k+1]  = rem_reg[k] - trial;
                root_next[k+1] = (root_reg[k] >> 1) + bitv;
            end
            else
            begin
                rem_next[k+1]  = rem_reg[k];
                root_next[k+1] = root_reg[k] >> 1;
            end
            clip_next[k+1] = clip_reg[k];
            last_next[k+1] = last_reg[k];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            st_valid_reg <= '0;
        end
        else
        begin
            sq_valid_reg <= grad_valid;
            st_valid_reg <= st_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        sqx_reg     <= prod_x[SQ_W-1:0];
        sqy_reg     <= prod_y[SQ_W-1:0];
        sq_last_reg <= grad_last;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        clip_reg    <= clip_next;
        last_reg    <= last_next;
    end

    // saturate on overflow
    assign mag_valid             = st_valid_reg[SQRT_STEPS];
    assign mag_res.clipped       = clip_reg[SQRT_STEPS];
    assign mag_res.last_of_frame = last_reg[SQRT_STEPS];
    assign mag_res.edge_value    = clip_reg[SQRT_STEPS] ? EDGE_MAX
                                 : root_reg[SQRT_STEPS][PIX_W-1:0];

endmodule

FILE: hw/rtl/sem_out_queue.sv
// result queue between the fixed-latency pipeline and the output channel
// uses sem_pkg for the result type and depth
module sem_out_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sem_pkg::res_t push_res,
    input  logic          pop,
    output logic          head_valid,
    output sem_pkg::res_t head_res
);
    import sem_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    res_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [OUTS_W-1:0] count_reg;
    logic [OUTS_W-1:0] count_next;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + OUTS_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - OUTS_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_res;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_res   = slot_reg[rd_ptr_reg];

endmodule

FILE: hw/rtl/sobel_edge_magnitude.sv
// sobel edge magnitude: a result passes the line store, gradient, square and root
// stage registers after its pixel is taken and waits in a 16 deep queue; one pixel per cycle
// is accepted while fewer than 16 results are outstanding, set by the queue size
// line stores take one read and one write per cycle in the same memory
// reset clears counters, window, queue and valid bits, sets both sizes to 1024;
// line store contents are undefined until written
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sem_pkg::PADDR_W-1:0]   paddr,
    input  logic [sem_pkg::PDATA_W-1:0]   pwdata,
    output logic [sem_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic [sem_pkg::PIX_W-1:0]     pixel,
    input  logic                          first_of_frame,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [sem_pkg::PIX_W-1:0]     edge_value,
    output logic                          clipped,
    output logic                          last_of_frame
);
    import sem_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [XW-1:0]     col_reg;
    logic [XW-1:0]     col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [OUTS_W-1:0] outstanding_reg;
    logic [OUTS_W-1:0] outstanding_next;

    logic [WW-1:0]     width_ext;
    logic [WW-1:0]     width_eff;
    logic [WW-1:0]     width_last;
    logic [CFG_W-1:0]  height_eff;
    logic [CFG_W-1:0]  height_last;
    logic [XW-1:0]     x_cur;
    logic [ROW_W-1:0]  y_cur;
    logic              row_end;
    logic              frame_end;
    logic              pix_accept;
    logic              res_accept;
    tag_t              pix_tag;

    logic              ls_valid;
    logic [PIX_W-1:0]  ls_pixel;
    logic [PIX_W-1:0]  ls_upper;
    logic [PIX_W-1:0]  ls_lower;
    tag_t              ls_tag;
    logic                     grad_valid;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     grad_last;
    logic              mag_valid;
    res_t              mag_res;
    res_t              head_res;

    // register port
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(SIZE_RESET);
            height_reg <= CFG_W'(SIZE_RESET);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp the frame size
    always_comb
    begin
        width_ext = WW'(width_reg);
        if (width_ext < WW'(MIN_SIZE))
        begin
            width_eff = WW'(MIN_SIZE);
        end
        else if (width_ext > WW'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        if (height_reg < CFG_W'(MIN_SIZE))
        begin
            height_eff = CFG_W'(MIN_SIZE);
        end
        else if (height_reg > CFG_W'(MAX_HEIGHT))
        begin
            height_eff = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = height_reg;
        end
        width_last  = width_eff - WW'(1);
        height_last = height_eff - CFG_W'(1);
    end

    // position of the incoming pixel and the counters after it
    assign pix_accept = pix_valid && !pix_stall;
    assign res_accept = res_valid && !res_stall;

    always_comb
    begin
        x_cur     = first_of_frame ? '0 : col_reg;
        y_cur     = first_of_frame ? '0 : row_reg;
        row_end   = WW'(x_cur) >= width_last;
        frame_end = CFG_W'(y_cur) >= height_last;
        pix_tag.produce = (x_cur >= XW'(2)) && (y_cur >= ROW_W'(2));
        pix_tag.last    = row_end && frame_end;
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : y_cur + ROW_W'(1);
        end
        else
        begin
            col_next = x_cur + XW'(1);
            row_next = y_cur;
        end
    end

    // results that are promised a queue slot
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (pix_accept && pix_tag.produce && !res_accept)
        begin
            outstanding_next = outstanding_reg + OUTS_W'(1);
        end
        else if (res_accept && !(pix_accept && pix_tag.produce))
        begin
            outstanding_next = outstanding_reg - OUTS_W'(1);
        end
    end

    assign pix_stall = (outstanding_reg >= OUTS_W'(QUEUE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
            if (pix_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // datapath
    sem_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (pix_accept),
        .req_addr  (x_cur),
        .req_pixel (pixel),
        .req_tag   (pix_tag),
        .rsp_valid (ls_valid),
        .rsp_pixel (ls_pixel),
        .rsp_upper (ls_upper),
        .rsp_lower (ls_lower),
        .rsp_tag   (ls_tag)
    );

    sem_gradient u_gradient (
        .clk        (clk),
        .rst_n      (rst_n),
        .col_valid  (ls_valid),
        .col_tag    (ls_tag),
        .col_pixel  (ls_pixel),
        .col_upper  (ls_upper),
        .col_lower  (ls_lower),
        .grad_valid (grad_valid),
        .gx         (gx),
        .gy         (gy),
        .grad_last  (grad_last)
    );

    sem_magnitude u_magnitude (
        .clk        (clk),
        .rst_n      (rst_n),
        .grad_valid (grad_valid),
        .gx         (gx),
        .gy         (gy),
        .grad_last  (grad_last),
        .mag_valid  (mag_valid),
        .mag_res    (mag_res)
    );

    sem_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (mag_valid),
        .push_res   (mag_res),
        .pop        (res_accept),
        .head_valid (res_valid),
        .head_res   (head_res)
    );

    assign edge_value    = head_res.edge_value;
    assign clipped       = head_res.clipped;
    assign last_of_frame = head_res.last_of_frame;

    // checks
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= OUTS_W'(QUEUE_DEPTH))
        else $error("outstanding result count beyond queue depth");

    a_result_promised: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (outstanding_reg != '0))
        else $error("result offered without an outstanding request");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_accept && first_of_frame) |=> (col_reg == XW'(1) && row_reg == '0))
        else $error("counters not restarted by first_of_frame");

endmodule

FILE: tb/tb_sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// self-checking testbench for sobel_edge_magnitude: pixel requests in, edge results out
// depends on sem_pkg and the sobel_edge_magnitude top level only
module tb_sobel_edge_magnitude;

    // result pipeline depth given for the block, used for settle waits
    localparam int PIPE_LATENCY = 12;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int HEAVY_PCT    = 74;
    localparam int LIGHT_PCT    = 18;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    // three 3x3 frames: strong clipped edge, just-unclipped 255, small negative gradient
    localparam logic [7:0] OPENING_PIX [0:26] = '{
        8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255,
        8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd63,
        8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd110, 8'd103, 8'd90
    };

    // predictor of the edge stream plus the queue of edges still owed by the block
    class edge_tracker;
        logic [sem_pkg::CFG_W-1:0] width_reg;
        logic [sem_pkg::CFG_W-1:0] height_reg;
        logic [7:0]                upper_row [sem_pkg::MAX_WIDTH_DEF];
        logic [7:0]                lower_row [sem_pkg::MAX_WIDTH_DEF];
        logic [7:0]                win [3][3];
        int unsigned               col;
        int unsigned               row;
        sem_pkg::res_t             edges_due [$];
        int                        mismatch_count;

        function new();
            width_reg      = sem_pkg::SIZE_RESET[sem_pkg::CFG_W-1:0];
            height_reg     = sem_pkg::SIZE_RESET[sem_pkg::CFG_W-1:0];
            col            = 0;
            row            = 0;
            mismatch_count = 0;
            foreach (upper_row[i])
            begin
                upper_row[i] = '0;
                lower_row[i] = '0;
            end
            foreach (win[r, c])
                win[r][c] = '0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [31:0] data);
            if (idx == sem_pkg::REG_WIDTH)
                width_reg = data[sem_pkg::CFG_W-1:0];
            else
                height_reg = data[sem_pkg::CFG_W-1:0];
        endfunction

        function int unsigned bounded_size(logic [sem_pkg::CFG_W-1:0] v, int unsigned hi);
            if (v < sem_pkg::MIN_SIZE)
                return sem_pkg::MIN_SIZE;
            if (v > hi)
                return hi;
            return int'(v);
        endfunction

        // bitwise floor square root, magnitude already known below 65536
        function logic [7:0] floor_root(int unsigned v);
            int unsigned r;
            int unsigned t;
            r = 0;
            for (int b = 7; b >= 0; b--)
            begin
                t = r | (32'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r[7:0];
        endfunction

        // advance line stores, window and counters for one accepted pixel
        function void take_pixel(logic [7:0] px, logic mark);
            int unsigned   w;
            int unsigned   h;
            int unsigned   x;
            int unsigned   y;
            int unsigned   a;
            int unsigned   mag2;
            int            p [3][3];
            int            gx;
            int            gy;
            logic [7:0]    up;
            logic [7:0]    lo;
            sem_pkg::res_t want;
            w = bounded_size(width_reg, sem_pkg::MAX_WIDTH_DEF);
            h = bounded_size(height_reg, sem_pkg::MAX_HEIGHT);
            if (mark)
            begin
                col = 0;
                row = 0;
            end
            x = col;
            y = row;
            a = x % sem_pkg::MAX_WIDTH_DEF;

            // both line stores read and shifted down at this column
            up = upper_row[a];
            lo = lower_row[a];
            upper_row[a] = lo;
            lower_row[a] = px;

            // window moves one column left, newest column enters on the right
            for (int r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = up;
            win[1][2] = lo;
            win[2][2] = px;

            // interior pixel: both kernels and the magnitude
            if (x >= 2 && y >= 2)
            begin
                foreach (p[r, c])
                    p[r][c] = int'(win[r][c]);
                gx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
                gy = (p[0][0] - p[2][0]) + 2 * (p[0][1] - p[2][1]) + (p[0][2] - p[2][2]);
                mag2 = gx * gx + gy * gy;
                if (mag2 >= 65536)
                begin
                    want.edge_value = sem_pkg::EDGE_MAX;
                    want.clipped    = 1'b1;
                end
                else
                begin
                    want.edge_value = floor_root(mag2);
                    want.clipped    = 1'b0;
                end
                want.last_of_frame = (x >= w - 1 && y >= h - 1);
                edges_due.push_back(want);
            end

            // column wraps at the row end, row wraps at the frame end
            if (x >= w - 1)
            begin
                col = 0;
                row = (y >= h - 1) ? 0 : y + 1;
            end
            else
                col = x + 1;
        endfunction

        function void log_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        // compare one accepted result against the oldest owed edge
        function void match_edge(logic [7:0] ev, logic cl, logic lf);
            sem_pkg::res_t want;
            if (edges_due.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result edge %0d clipped %b last %b",
                                       ev, cl, lf));
                return;
            end
            want = edges_due.pop_front();
            if (ev !== want.edge_value || cl !== want.clipped || lf !== want.last_of_frame)
                log_mismatch($sformatf(
                    "edge exp %0d got %0d, clipped exp %b got %b, last exp %b got %b",
                    want.edge_value, ev, want.clipped, cl, want.last_of_frame, lf));
        endfunction

        function int pending();
            return edges_due.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sem_pkg::PADDR_W-1:0]   paddr;
    logic [sem_pkg::PDATA_W-1:0]   pwdata;
    logic [sem_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          pix_valid;
    logic                          pix_stall;
    logic [sem_pkg::PIX_W-1:0]     pixel;
    logic                          first_of_frame;
    logic                          res_valid;
    logic                          res_stall;
    logic [sem_pkg::PIX_W-1:0]     edge_value;
    logic                          clipped;
    logic                          last_of_frame;

    edge_tracker board;
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    logic [7:0]  flat_level      = 8'd100;
    int          texture         = 0;

    sobel_edge_magnitude i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .pixel          (pixel),
        .first_of_frame (first_of_frame),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .edge_value     (edge_value),
        .clipped        (clipped),
        .last_of_frame  (last_of_frame)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("sobel_edge_magnitude verification failed");
        $finish;
    end

    // result side: random stall and check of every accepted result
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            board.match_edge(edge_value, clipped, last_of_frame);
        res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // pixel content in stretches: noisy, near-flat, or a wider spread around a level
    function automatic logic [7:0] pick_pixel();
        int pick;
        if ($urandom_range(0, 31) == 0)
            texture = $urandom_range(0, 2);
        if ($urandom_range(0, 15) == 0)
            flat_level = 8'($urandom_range(0, 192));
        pick = $urandom_range(0, 9);
        if (texture == 0)
        begin
            if (pick == 0)
                return 8'd0;
            if (pick == 1)
                return 8'hFF;
            return 8'($urandom_range(0, 255));
        end
        if (texture == 1)
            return 8'(flat_level + $urandom_range(0, 7));
        return 8'(flat_level + $urandom_range(0, 63));
    endfunction

    task automatic set_idling(idle_mode_e mode);
        sender_idle_pct = (mode == IDLE_SENDER) ? HEAVY_PCT :
                          (mode == IDLE_BOTH)   ? LIGHT_PCT : 0;
        recv_stall_pct  = (mode == IDLE_RECEIVER) ? HEAVY_PCT :
                          (mode == IDLE_BOTH)     ? LIGHT_PCT : 0;
    endtask

    // one register write: setup cycle, then access until pready
    task automatic write_reg(logic [0:0] idx, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one pixel request, held until the block takes it
    task automatic send_pixel(logic [7:0] px, logic mark);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid      <= 1'b1;
        pixel          <= px;
        first_of_frame <= mark;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        board.take_pixel(px, mark);
    endtask

    task automatic run_stream(int count, bit start_mark, int mark_noise_pct);
        logic mark;
        for (int i = 0; i < count; i++)
        begin
            mark = (i == 0 && start_mark) || ($urandom_range(0, 99) < mark_noise_pct);
            send_pixel(pick_pixel(), mark);
        end
        pix_valid <= 1'b0;
    endtask

    // all owed edges in, then let the pipeline settle
    task automatic wait_for_quiet();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic start_phase(logic [31:0] w_data, logic [31:0] h_data, idle_mode_e mode);
        wait_for_quiet();
        write_reg(sem_pkg::REG_WIDTH, w_data);
        write_reg(sem_pkg::REG_HEIGHT, h_data);
        set_idling(mode);
    endtask

    // main sequence
    initial
    begin
        board          = new();
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        pix_valid      <= 1'b0;
        pixel          <= '0;
        first_of_frame <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // smallest frames; the second one starts by wrapping, with no frame mark
        start_phase(32'd3, 32'd3, IDLE_NONE);
        for (int i = 0; i < 27; i++)
            send_pixel(OPENING_PIX[i], i == 0 || i == 18);
        pix_valid <= 1'b0;

        // 7x5 frames, stopping at row 4 column 5 of the second frame
        start_phase(32'd7, 32'd5, IDLE_SENDER);
        run_stream(68, 1'b1, 0);

        // shrink mid-frame: both counters sit past the new last position
        start_phase(32'd4, 32'd3, IDLE_RECEIVER);
        run_stream(50, 1'b0, 2);

        // widest row, upper bits of the write data set; start of the first row only
        start_phase(32'hFFFF_F400, 32'd3, IDLE_BOTH);
        run_stream(40, 1'b1, 0);

        // width below range, height above range
        start_phase(32'd0, 32'hFFFF_FFFF, IDLE_RECEIVER);
        run_stream(60, 1'b1, 0);

        // both sizes below range
        start_phase(32'd2, 32'd1, IDLE_NONE);
        run_stream(40, 1'b1, 3);

        // random small frames across all idling modes
        for (int k = 0; k < 8; k++)
        begin
            start_phase($urandom_range(3, 12), $urandom_range(3, 6), idle_mode_e'(k % 4));
            run_stream(30, 1'b1, 2);
        end

        // width above range clamps to the widest row
        start_phase(32'd1500, 32'd4, IDLE_SENDER);
        run_stream(30, 1'b1, 0);

        wait_for_quiet();
        if (board.mismatch_count == 0 && board.pending() == 0)
            $display("sobel_edge_magnitude verification clean");
        else
            $display("sobel_edge_magnitude verification failed");
        $finish;
    end

endmodule

FILE: sobel_edge_magnitude.f
hw/rtl/sem_pkg.sv
hw/rtl/sem_line_store.sv
hw/rtl/sem_gradient.sv
hw/rtl/sem_magnitude.sv
hw/rtl/sem_out_queue.sv
hw/rtl/sobel_edge_magnitude.sv
tb/tb_sobel_edge_magnitude.sv
